@@ hdl/wmi_pkg.sv @@
// wmi_pkg: shared constants and register codes of the weighted mutual information block
// no dependencies; used by weighted_mutual_information_top
package wmi_pkg;

    localparam int MAX_CATEGORIES_DEF   = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int CAT_FIELD_W = 4;
    localparam int WEIGHT_W    = 17;
    localparam int COUNT_W     = 5;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;
    localparam int CELL_W      = 34;
    localparam int RATIO_W     = 33;
    localparam int MANT_W      = 31;
    localparam int FRAC_W      = 30;
    localparam int K_W         = 6;
    localparam int LOG_W       = 36;
    localparam int LNV_W       = 35;
    localparam int LACC_W      = 52;
    localparam int TERM_W      = 30;
    localparam int STEP_W      = 5;
    localparam int DIV_STEPS   = 32;
    localparam int SQ_STEPS    = 30;

    localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
    localparam logic [CELL_W-1:0] CELL_MAX = '1;

    typedef enum logic [1:0] {
        REG_FIRST_COUNT  = 2'd0,
        REG_SECOND_COUNT = 2'd1,
        REG_MI_THRESHOLD = 2'd2
    } reg_index_t;

endpackage

@@ hdl/weighted_mutual_information_top.sv @@
// weighted_mutual_information_top: weighted joint table, final normalize and log pass, result
// depends on wmi_pkg and wmi_ram
//
// Accumulates weighted samples (first_category, second_category, weight Q1.16) into a joint
// table held in a ram, one cell per category pair. Each sample passes through accept, ram
// read and saturating write back; s_ready is low meanwhile. A sample with last set closes
// the set: after its own update, one pass adds the half pseudocount to every active cell
// and forms row, column and grand totals. Then each of the nf + ns + nf*ns probabilities
// goes through one shared sequencer: a 33 step restoring divide, a normalize shift, 30
// squaring steps for log2, and a subtract plus 4 multiply steps for the ln and the p*ln p
// product; the squaring and multiply steps share a single 33x32 multiplier. The result item
// (mi_value Q4.28 nats, above_threshold, range_error) is held on the m_ channel until taken,
// and the table clears in that same cycle through per-cell valid bits, so no clearing pass
// is needed after reset or between sets. Samples with a category at or above the active
// count are dropped and reported in range_error.
// Write configuration over the apb port only while the block is idle; it is not enforced.
module weighted_mutual_information_top #(
    parameter int MAX_CATEGORIES   = wmi_pkg::MAX_CATEGORIES_DEF,
    parameter int WEIGHT_FRAC_BITS = wmi_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wmi_pkg::PADDR_W-1:0]        paddr,
    input  logic [wmi_pkg::DATA_W-1:0]         pwdata,
    output logic [wmi_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // sample items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wmi_pkg::CAT_FIELD_W-1:0]    s_first_category,
    input  logic [wmi_pkg::CAT_FIELD_W-1:0]    s_second_category,
    input  logic [WEIGHT_FRAC_BITS:0]          s_weight,
    input  logic                               s_last,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [wmi_pkg::DATA_W-1:0]         m_mi_value,
    output logic                               m_above_threshold,
    output logic                               m_range_error
);

    localparam int CAT_W  = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int CNT_W  = $clog2(MAX_CATEGORIES + 1);
    localparam int CMP_W  = (CNT_W > wmi_pkg::COUNT_W) ? CNT_W : wmi_pkg::COUNT_W;
    localparam int ADDR_W = 2 * CAT_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int SUM_W  = wmi_pkg::CELL_W + 1;
    localparam int ROW_W  = SUM_W + CAT_W;
    localparam int TOT_W  = SUM_W + 2 * CAT_W;
    localparam int ACC_W  = wmi_pkg::TERM_W + 2 * CAT_W + 2;

    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (WEIGHT_FRAC_BITS - 1);
    localparam logic [wmi_pkg::LOG_W-1:0] LOG_LIM =
        wmi_pkg::LOG_W'(32) << wmi_pkg::FRAC_W;

    // one-hot sequencer
    typedef enum logic [21:0] {
        S_IDLE     = 22'b0000000000000000000001,
        S_RD       = 22'b0000000000000000000010,
        S_WR       = 22'b0000000000000000000100,
        S_SUM_INIT = 22'b0000000000000000001000,
        S_SUM_RD   = 22'b0000000000000000010000,
        S_SUM_ACC  = 22'b0000000000000000100000,
        S_NEXT     = 22'b0000000000000001000000,
        S_CELL_RD  = 22'b0000000000000010000000,
        S_CELL_LD  = 22'b0000000000000100000000,
        S_DIV0     = 22'b0000000000001000000000,
        S_DIV      = 22'b0000000000010000000000,
        S_PCHK     = 22'b0000000000100000000000,
        S_NORM     = 22'b0000000001000000000000,
        S_SQ       = 22'b0000000010000000000000,
        S_VCALC    = 22'b0000000100000000000000,
        S_LNH      = 22'b0000001000000000000000,
        S_LNL      = 22'b0000010000000000000000,
        S_PH       = 22'b0000100000000000000000,
        S_PL       = 22'b0001000000000000000000,
        S_ACC      = 22'b0010000000000000000000,
        S_FIN      = 22'b0100000000000000000000,
        S_OUT      = 22'b1000000000000000000000
    } state_t;

    // which group of probabilities the term loop is walking
    typedef enum logic [1:0] {
        SRC_ROW  = 2'd0,
        SRC_COL  = 2'd1,
        SRC_CELL = 2'd2
    } src_t;

    // configuration registers
    logic [wmi_pkg::COUNT_W-1:0] first_count_reg;
    logic [wmi_pkg::COUNT_W-1:0] second_count_reg;
    logic [wmi_pkg::DATA_W-1:0]  mi_threshold_reg;
    wmi_pkg::reg_index_t         cfg_index;
    logic                        cfg_wr;

    // control
    state_t state_reg, state_next;
    src_t   src_reg, src_next;
    logic   bad_reg, bad_next;
    logic   m_valid_reg, m_valid_next;
    logic [DEPTH-1:0] valid_reg;

    // latched sample
    logic [CAT_W-1:0]             fc_reg, fc_next;
    logic [CAT_W-1:0]             sc_reg, sc_next;
    logic [WEIGHT_FRAC_BITS:0]    w_reg, w_next;
    logic                         last_reg, last_next;
    logic                         inr_reg, inr_next;

    // final pass datapath
    logic [CAT_W-1:0]              i_reg, i_next;
    logic [CAT_W-1:0]              j_reg, j_next;
    logic [TOT_W-1:0]              total_reg, total_next;
    logic [TOT_W-1:0]              num_reg, num_next;
    logic [TOT_W-1:0]              r_reg, r_next;
    logic [wmi_pkg::RATIO_W-1:0]   q_reg, q_next;
    logic [wmi_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [wmi_pkg::RATIO_W-1:0]   m_reg, m_next;
    logic [wmi_pkg::MANT_W-1:0]    mant_reg, mant_next;
    logic [wmi_pkg::K_W-1:0]       k_reg, k_next;
    logic [wmi_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [wmi_pkg::LOG_W-1:0]     v_reg, v_next;
    logic [wmi_pkg::LACC_W-1:0]    lacc_reg, lacc_next;
    logic [wmi_pkg::LNV_W-1:0]     lnv_reg, lnv_next;
    logic [wmi_pkg::LACC_W-1:0]    hi_reg, hi_next;
    logic [wmi_pkg::TERM_W-1:0]    term_reg, term_next;
    logic [ACC_W-1:0]              pos_reg, pos_next;
    logic [ACC_W-1:0]              neg_reg, neg_next;
    logic [wmi_pkg::DATA_W-1:0]    mi_reg, mi_next;
    logic                          above_reg, above_next;
    logic                          rerr_reg, rerr_next;

    logic [ROW_W-1:0] row_reg [MAX_CATEGORIES];
    logic [ROW_W-1:0] col_reg [MAX_CATEGORIES];

    // joint table ram
    logic [ADDR_W-1:0]          ram_addr;
    logic                       ram_we;
    logic [wmi_pkg::CELL_W-1:0] ram_wdata;
    logic [wmi_pkg::CELL_W-1:0] ram_rdata;
    logic [wmi_pkg::CELL_W-1:0] cell_val;
    logic [SUM_W-1:0]           cell_c;
    logic [SUM_W-1:0]           wsum;

    // shared multiplier
    logic [wmi_pkg::RATIO_W-1:0] mul_a;
    logic [31:0]                 mul_b;
    logic [64:0]                 mul_p;

    logic [CNT_W-1:0] nf, ns;
    logic             i_last, j_last;
    logic             s_in_range;
    logic             s_fire, m_fire;
    logic [TOT_W:0]   r2;
    logic [31:0]      sq;
    logic [wmi_pkg::LOG_W-1:0] y;
    logic [ACC_W-1:0] diff;

    // ---------------------------------------------------------------------------------------
    // configuration port, always ready, register i at byte address 4*i
    // ---------------------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign cfg_index = wmi_pkg::reg_index_t'(paddr[3:2]);

    always_comb begin
        case (cfg_index)
            wmi_pkg::REG_FIRST_COUNT:  prdata = wmi_pkg::DATA_W'(first_count_reg);
            wmi_pkg::REG_SECOND_COUNT: prdata = wmi_pkg::DATA_W'(second_count_reg);
            wmi_pkg::REG_MI_THRESHOLD: prdata = mi_threshold_reg;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_count_reg  <= wmi_pkg::COUNT_W'(2);
            second_count_reg <= wmi_pkg::COUNT_W'(2);
            mi_threshold_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                wmi_pkg::REG_FIRST_COUNT:  first_count_reg  <= pwdata[wmi_pkg::COUNT_W-1:0];
                wmi_pkg::REG_SECOND_COUNT: second_count_reg <= pwdata[wmi_pkg::COUNT_W-1:0];
                wmi_pkg::REG_MI_THRESHOLD: mi_threshold_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // active counts: zero acts as one, anything above the table size acts as the table size
    always_comb begin
        if (first_count_reg == '0) begin
            nf = CNT_W'(1);
        end else if (CMP_W'(first_count_reg) > CMP_W'(MAX_CATEGORIES)) begin
            nf = CNT_W'(MAX_CATEGORIES);
        end else begin
            nf = CNT_W'(first_count_reg);
        end
        if (second_count_reg == '0) begin
            ns = CNT_W'(1);
        end else if (CMP_W'(second_count_reg) > CMP_W'(MAX_CATEGORIES)) begin
            ns = CNT_W'(MAX_CATEGORIES);
        end else begin
            ns = CNT_W'(second_count_reg);
        end
    end

    assign i_last = (i_reg == CAT_W'(nf - CNT_W'(1)));
    assign j_last = (j_reg == CAT_W'(ns - CNT_W'(1)));
    assign s_in_range = (CMP_W'(s_first_category) < CMP_W'(nf)) &&
                        (CMP_W'(s_second_category) < CMP_W'(ns));

    // ---------------------------------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------------------------------
    assign s_ready           = (state_reg == S_IDLE);
    assign s_fire            = s_valid & s_ready;
    assign m_valid           = m_valid_reg;
    assign m_fire            = m_valid_reg & m_ready;
    assign m_mi_value        = mi_reg;
    assign m_above_threshold = above_reg;
    assign m_range_error     = rerr_reg;

    // ---------------------------------------------------------------------------------------
    // joint table: a cell whose valid bit is clear reads as zero
    // ---------------------------------------------------------------------------------------
    assign ram_addr  = ((state_reg == S_RD) || (state_reg == S_WR)) ? {fc_reg, sc_reg}
                                                                   : {i_reg, j_reg};
    assign cell_val  = valid_reg[ram_addr] ? ram_rdata : '0;
    assign cell_c    = SUM_W'(cell_val) + HALF;
    assign wsum      = SUM_W'(cell_val) + SUM_W'(w_reg);
    assign ram_wdata = wsum[wmi_pkg::CELL_W] ? wmi_pkg::CELL_MAX : wsum[wmi_pkg::CELL_W-1:0];
    assign ram_we    = (state_reg == S_WR) && inr_reg;

    wmi_ram #(
        .WIDTH (wmi_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------------------------------
    // shared multiplier: squaring for log2, v*ln2 in two halves, p*ln in two halves
    // ---------------------------------------------------------------------------------------
    always_comb begin
        case (state_reg)
            S_SQ: begin
                mul_a = wmi_pkg::RATIO_W'(mant_reg);
                mul_b = 32'(mant_reg);
            end
            S_LNH: begin
                mul_a = wmi_pkg::RATIO_W'(v_reg[wmi_pkg::LOG_W-1:16]);
                mul_b = wmi_pkg::LN2_Q32;
            end
            S_LNL: begin
                mul_a = wmi_pkg::RATIO_W'(v_reg[15:0]);
                mul_b = wmi_pkg::LN2_Q32;
            end
            S_PH: begin
                mul_a = q_reg;
                mul_b = 32'(lnv_reg[wmi_pkg::LNV_W-1:16]);
            end
            S_PL: begin
                mul_a = q_reg;
                mul_b = 32'(lnv_reg[15:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'b0, mul_a} * {33'b0, mul_b};
    assign sq    = mul_p[61:30];
    assign r2    = {r_reg, 1'b0};
    assign y     = {k_reg, frac_reg};
    assign diff  = pos_reg - neg_reg;

    // ---------------------------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        src_next     = src_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg;
        fc_next      = fc_reg;
        sc_next      = sc_reg;
        w_next       = w_reg;
        last_next    = last_reg;
        inr_next     = inr_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        total_next   = total_reg;
        num_next     = num_reg;
        r_next       = r_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        m_next       = m_reg;
        mant_next    = mant_reg;
        k_next       = k_reg;
        frac_next    = frac_reg;
        v_next       = v_reg;
        lacc_next    = lacc_reg;
        lnv_next     = lnv_reg;
        hi_next      = hi_reg;
        term_next    = term_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        mi_next      = mi_reg;
        above_next   = above_reg;
        rerr_next    = rerr_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    fc_next    = CAT_W'(s_first_category);
                    sc_next    = CAT_W'(s_second_category);
                    w_next     = s_weight;
                    last_next  = s_last;
                    inr_next   = s_in_range;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                // in-range write happens through ram_we; dropped item only marks the set
                if (!inr_reg) begin
                    bad_next = 1'b1;
                end
                state_next = last_reg ? S_SUM_INIT : S_IDLE;
            end
            S_SUM_INIT: begin
                i_next     = '0;
                j_next     = '0;
                total_next = '0;
                pos_next   = '0;
                neg_next   = '0;
                state_next = S_SUM_RD;
            end
            S_SUM_RD: begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                total_next = total_reg + TOT_W'(cell_c);
                state_next = S_SUM_RD;
                if (j_last) begin
                    j_next = '0;
                    if (i_last) begin
                        i_next     = '0;
                        src_next   = SRC_ROW;
                        state_next = S_NEXT;
                    end else begin
                        i_next = i_reg + CAT_W'(1);
                    end
                end else begin
                    j_next = j_reg + CAT_W'(1);
                end
            end
            S_NEXT: begin
                case (src_reg)
                    SRC_ROW: begin
                        num_next   = TOT_W'(row_reg[i_reg]);
                        state_next = S_DIV0;
                    end
                    SRC_COL: begin
                        num_next   = TOT_W'(col_reg[j_reg]);
                        state_next = S_DIV0;
                    end
                    default: begin
                        state_next = S_CELL_RD;
                    end
                endcase
            end
            S_CELL_RD: begin
                state_next = S_CELL_LD;
            end
            S_CELL_LD: begin
                num_next   = TOT_W'(cell_c);
                state_next = S_DIV0;
            end
            S_DIV0: begin
                // integer part of num/total is 0 or 1
                if (num_reg >= total_reg) begin
                    q_next = wmi_pkg::RATIO_W'(1);
                    r_next = num_reg - total_reg;
                end else begin
                    q_next = '0;
                    r_next = num_reg;
                end
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                // one restoring step a cycle, 32 fraction bits
                if (r2 >= {1'b0, total_reg}) begin
                    r_next = TOT_W'(r2 - {1'b0, total_reg});
                    q_next = {q_reg[wmi_pkg::RATIO_W-2:0], 1'b1};
                end else begin
                    r_next = TOT_W'(r2);
                    q_next = {q_reg[wmi_pkg::RATIO_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + wmi_pkg::STEP_W'(1);
                if (cnt_reg == wmi_pkg::STEP_W'(wmi_pkg::DIV_STEPS - 1)) begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK: begin
                if (q_reg == '0) begin
                    term_next  = '0;
                    state_next = S_ACC;
                end else begin
                    m_next     = q_reg;
                    k_next     = wmi_pkg::K_W'(32);
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                // left shift until the top bit is set, k tracks the msb position
                if (m_reg[wmi_pkg::RATIO_W-1]) begin
                    mant_next  = m_reg[wmi_pkg::RATIO_W-1:2];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQ;
                end else begin
                    m_next = {m_reg[wmi_pkg::RATIO_W-2:0], 1'b0};
                    k_next = k_reg - wmi_pkg::K_W'(1);
                end
            end
            S_SQ: begin
                // square the q1.30 mantissa, one log2 fraction bit per step
                if (sq[31]) begin
                    mant_next = sq[31:1];
                    frac_next = frac_reg | (wmi_pkg::FRAC_W'(1) <<
                                (wmi_pkg::STEP_W'(wmi_pkg::SQ_STEPS - 1) - cnt_reg));
                end else begin
                    mant_next = sq[30:0];
                end
                cnt_next = cnt_reg + wmi_pkg::STEP_W'(1);
                if (cnt_reg == wmi_pkg::STEP_W'(wmi_pkg::SQ_STEPS - 1)) begin
                    state_next = S_VCALC;
                end
            end
            S_VCALC: begin
                // v = 32 - y, the -log2 of the probability
                v_next     = (y >= LOG_LIM) ? '0 : LOG_LIM - y;
                state_next = S_LNH;
            end
            S_LNH: begin
                lacc_next  = mul_p[wmi_pkg::LACC_W-1:0];
                state_next = S_LNL;
            end
            S_LNL: begin
                lnv_next   = wmi_pkg::LNV_W'(({1'b0, lacc_reg} + 53'(mul_p[47:16])) >> 18);
                state_next = S_PH;
            end
            S_PH: begin
                hi_next    = mul_p[wmi_pkg::LACC_W-1:0];
                state_next = S_PL;
            end
            S_PL: begin
                term_next  = wmi_pkg::TERM_W'(({1'b0, hi_reg} + 53'(mul_p[48:16])) >> 16);
                state_next = S_ACC;
            end
            S_ACC: begin
                state_next = S_NEXT;
                case (src_reg)
                    SRC_ROW: begin
                        pos_next = pos_reg + ACC_W'(term_reg);
                        if (i_last) begin
                            src_next = SRC_COL;
                            j_next   = '0;
                        end else begin
                            i_next = i_reg + CAT_W'(1);
                        end
                    end
                    SRC_COL: begin
                        pos_next = pos_reg + ACC_W'(term_reg);
                        if (j_last) begin
                            src_next = SRC_CELL;
                            i_next   = '0;
                            j_next   = '0;
                        end else begin
                            j_next = j_reg + CAT_W'(1);
                        end
                    end
                    default: begin
                        neg_next = neg_reg + ACC_W'(term_reg);
                        if (j_last) begin
                            j_next = '0;
                            if (i_last) begin
                                state_next = S_FIN;
                            end else begin
                                i_next = i_reg + CAT_W'(1);
                            end
                        end else begin
                            j_next = j_reg + CAT_W'(1);
                        end
                    end
                endcase
            end
            S_FIN: begin
                // negative from rounding gives zero, too large saturates
                if (pos_reg <= neg_reg) begin
                    mi_next = '0;
                end else if (|diff[ACC_W-1:wmi_pkg::DATA_W]) begin
                    mi_next = '1;
                end else begin
                    mi_next = diff[wmi_pkg::DATA_W-1:0];
                end
                rerr_next    = bad_reg;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                above_next = (mi_reg > mi_threshold_reg);
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    bad_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the threshold flag must be ready with the item, so compute it alongside mi in S_FIN
    logic above_fin;
    assign above_fin = (mi_next > mi_threshold_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
            if (m_fire) begin
                valid_reg <= '0;
            end else if (ram_we) begin
                valid_reg[ram_addr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        src_reg   <= src_next;
        fc_reg    <= fc_next;
        sc_reg    <= sc_next;
        w_reg     <= w_next;
        last_reg  <= last_next;
        inr_reg   <= inr_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        total_reg <= total_next;
        num_reg   <= num_next;
        r_reg     <= r_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        m_reg     <= m_next;
        mant_reg  <= mant_next;
        k_reg     <= k_next;
        frac_reg  <= frac_next;
        v_reg     <= v_next;
        lacc_reg  <= lacc_next;
        lnv_reg   <= lnv_next;
        hi_reg    <= hi_next;
        term_reg  <= term_next;
        pos_reg   <= pos_next;
        neg_reg   <= neg_next;
        mi_reg    <= mi_next;
        rerr_reg  <= rerr_next;
        if (state_reg == S_FIN) begin
            above_reg <= above_fin;
        end else begin
            above_reg <= above_next;
        end
    end

    // row and column totals of the pseudocounted cells
    always_ff @(posedge aclk) begin
        if (state_reg == S_SUM_INIT) begin
            for (int n = 0; n < MAX_CATEGORIES; n++) begin
                row_reg[n] <= '0;
                col_reg[n] <= '0;
            end
        end else if (state_reg == S_SUM_ACC) begin
            row_reg[i_reg] <= row_reg[i_reg] + ROW_W'(cell_c);
            col_reg[j_reg] <= col_reg[j_reg] + ROW_W'(cell_c);
        end
    end

endmodule

@@ hdl/wmi_ram.sv @@
// wmi_ram: generic single write port, single read port ram with registered read
// no dependencies
module wmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/weighted_mutual_information_top_test.sv @@
`timescale 1ns / 1ps
// weighted_mutual_information_top_test: self-checking bench for the weighted mutual information block
// depends on wmi_pkg and weighted_mutual_information_top; predicts each result in fixed point
module weighted_mutual_information_top_test;

    localparam int NCAT = 16;
    localparam logic [63:0] CELL_LIMIT = (64'd1 << 34) - 1;

    // result item as seen on the m_ channel
    typedef struct {
        logic [31:0] mi_value;
        logic        above;
        logic        range_err;
    } mi_result_t;

    // one row of the directed table; has_fixed marks a typed-in expectation
    typedef struct {
        logic [3:0]  fcat;
        logic [3:0]  scat;
        logic [16:0] weight;
        logic        last;
        logic        has_fixed;
        logic [31:0] fixed_mi;
        logic        fixed_above;
        logic        fixed_err;
    } sample_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [wmi_pkg::PADDR_W-1:0] paddr;
    logic [wmi_pkg::DATA_W-1:0]  pwdata, prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [3:0]  s_first_category, s_second_category;
    logic [16:0] s_weight;
    logic        s_last;
    logic        m_valid, m_ready;
    logic [31:0] m_mi_value;
    logic        m_above_threshold, m_range_error;

    weighted_mutual_information_top dut (.*);

    // predictor state: configuration and joint table
    logic [4:0]  cfg_first_count, cfg_second_count;
    logic [31:0] cfg_threshold;
    logic [63:0] joint_cells [NCAT*NCAT];
    logic        bad_seen;

    mi_result_t  pending_results [$];
    int          mismatch_count;
    int          results_seen;
    longint      cycle_count;
    int          rx_mode;

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: worst case every item closes a full 16x16 set, ~1550 sets of 288 terms,
    // plus samples, stalls and gaps
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 64'd200000000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [63:0] count_eff(logic [4:0] v);
        if (v == 0) return 64'd1;
        if (v > NCAT) return 64'(NCAT);
        return 64'(v);
    endfunction

    // floor(num * 2^32 / den)
    function automatic logic [63:0] prob_q32(logic [63:0] num, logic [63:0] den);
        logic [63:0] q, r;
        if (den == 0) return 0;
        q = num / den;
        r = num % den;
        for (int k = 0; k < 32; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // log2 in Q.30 by squaring the Q1.30 mantissa
    function automatic logic [63:0] log2_fixed(logic [63:0] p);
        logic [63:0] m, y;
        int k;
        if (p == 0) return 0;
        k = 0;
        while (k < 63 && (p >> (k + 1)) != 0) k++;
        if (k <= 30) m = p << (30 - k);
        else m = p >> (k - 30);
        y = 64'(k) << 30;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                y[29-i] = 1'b1;
            end
        end
        return y;
    endfunction

    // p * -ln p in Q.28
    function automatic logic [63:0] plogp_term(logic [63:0] p);
        logic [63:0] y, v, vh, vl, lnv, lh, ll, hi, lo;
        if (p == 0) return 0;
        y = log2_fixed(p);
        v = 64'd32 << 30;
        v = (y >= v) ? 64'd0 : v - y;
        vh = v >> 16;
        vl = v & 64'hFFFF;
        lnv = (vh * 64'(wmi_pkg::LN2_Q32) + ((vl * 64'(wmi_pkg::LN2_Q32)) >> 16)) >> 18;
        lh = lnv >> 16;
        ll = lnv & 64'hFFFF;
        hi = p * lh;
        lo = p * ll;
        return (hi + (lo >> 16)) >> 16;
    endfunction

    function automatic void clear_table();
        foreach (joint_cells[i]) joint_cells[i] = 0;
        bad_seen = 0;
    endfunction

    // accumulate one sample; on last, queue the mutual information expectation
    function automatic void predict_sample(logic [3:0] fc, logic [3:0] sc,
                                           logic [16:0] w, logic lst);
        logic [63:0] nf, ns, half, total, pos, neg, mi, c, sum;
        logic [63:0] rows [NCAT];
        logic [63:0] cols [NCAT];
        mi_result_t res;
        nf = count_eff(cfg_first_count);
        ns = count_eff(cfg_second_count);
        half = 64'd1 << 15;
        if (fc < nf && sc < ns) begin
            sum = joint_cells[fc*NCAT+sc] + w;
            joint_cells[fc*NCAT+sc] = (sum > CELL_LIMIT) ? CELL_LIMIT : sum;
        end else begin
            bad_seen = 1;
        end
        if (!lst) return;
        total = 0; pos = 0; neg = 0;
        for (int i = 0; i < NCAT; i++) begin
            rows[i] = 0;
            cols[i] = 0;
        end
        for (int i = 0; i < nf; i++)
            for (int j = 0; j < ns; j++) begin
                c = joint_cells[i*NCAT+j] + half;
                rows[i] += c;
                cols[j] += c;
                total += c;
            end
        for (int i = 0; i < nf; i++) begin
            pos += plogp_term(prob_q32(rows[i], total));
            for (int j = 0; j < ns; j++)
                neg += plogp_term(prob_q32(joint_cells[i*NCAT+j] + half, total));
        end
        for (int j = 0; j < ns; j++) pos += plogp_term(prob_q32(cols[j], total));
        mi = (pos > neg) ? pos - neg : 64'd0;
        if (mi > 64'hFFFF_FFFF) mi = 64'hFFFF_FFFF;
        res.mi_value = mi[31:0];
        res.above = (mi[31:0] > cfg_threshold);
        res.range_err = bad_seen;
        pending_results = {pending_results, res};
        clear_table();
    endfunction

    // apb write: setup then access cycle
    task automatic write_register(wmi_pkg::reg_index_t idx, logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= wmi_pkg::PADDR_W'(4 * int'(idx)); pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            wmi_pkg::REG_FIRST_COUNT:  cfg_first_count = value[4:0];
            wmi_pkg::REG_SECOND_COUNT: cfg_second_count = value[4:0];
            default:                   cfg_threshold = value;
        endcase
    endtask

    task automatic set_counts(int nf, int ns, logic [31:0] thr);
        write_register(wmi_pkg::REG_FIRST_COUNT, 32'(nf));
        write_register(wmi_pkg::REG_SECOND_COUNT, 32'(ns));
        write_register(wmi_pkg::REG_MI_THRESHOLD, thr);
    endtask

    // send one item, holding valid until accepted; optional burst gap first
    task automatic send_sample(logic [3:0] fc, logic [3:0] sc, logic [16:0] w, logic lst,
                               bit gappy);
        if (gappy && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1;
        s_first_category <= fc;
        s_second_category <= sc;
        s_weight <= w;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sample(fc, sc, w, lst);
    endtask

    // settle: drop valid, drain results, then pad before the next set
    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // receiver: random stalls with changing pattern, some stretches always ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            case (rx_mode)
                0:       m_ready <= 1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result checker, sampled at the edge
    always @(posedge aclk) begin
        mi_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item mi=%h", m_mi_value);
            end else begin
                want = pending_results.pop_front();
                if (m_mi_value !== want.mi_value || m_above_threshold !== want.above
                        || m_range_error !== want.range_err) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp mi=%h above=%b err=%b got mi=%h above=%b err=%b",
                                 want.mi_value, want.above, want.range_err,
                                 m_mi_value, m_above_threshold, m_range_error);
                end
            end
        end
    end

    sample_row_t directed [$];

    function automatic void add_row(logic [3:0] f, logic [3:0] s, logic [16:0] w, logic l);
        sample_row_t r;
        r = '{f, s, w, l, 1'b0, 32'd0, 1'b0, 1'b0};
        directed = {directed, r};
    endfunction

    function automatic void add_fixed(logic [3:0] f, logic [3:0] s, logic [16:0] w, logic l,
                                      logic [31:0] mi, logic ab, logic er);
        sample_row_t r;
        r = '{f, s, w, l, 1'b1, mi, ab, er};
        directed = {directed, r};
    endfunction

    initial begin
        int sent, set_len, nf, ns;
        logic [3:0] f, s;
        logic [16:0] w;
        aresetn = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_first_category = 0; s_second_category = 0; s_weight = 0; s_last = 0;
        rx_mode = 0;
        mismatch_count = 0;
        results_seen = 0;
        cfg_first_count = 2; cfg_second_count = 2; cfg_threshold = 0;
        clear_table();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part at reset counts (2x2)
        // single sample with zero weight: uniform table, mi 0, not above zero threshold
        add_fixed(0, 0, 17'd0, 1, 32'd0, 0, 0);
        // out of range on both fields, set still closes with mi 0 and the error flag
        add_fixed(4'hF, 4'hF, 17'h1FFFF, 1, 32'd0, 0, 1);
        // strongly correlated diagonal at full weight
        add_row(0, 0, 17'd65536, 0);
        add_row(1, 1, 17'd65536, 0);
        add_row(0, 0, 17'h1FFFF, 0);
        add_row(1, 1, 17'h1FFFF, 1);
        // weight above 1.0 on off-diagonal, then a stray category mid set
        add_row(0, 1, 17'h1FFFF, 0);
        add_row(2, 0, 17'd100, 0);
        add_row(1, 0, 17'h15555, 1);
        foreach (directed[k]) begin
            send_sample(directed[k].fcat, directed[k].scat, directed[k].weight,
                        directed[k].last, 0);
            if (directed[k].has_fixed) begin
                // the typed value must agree with the predictor's own
                if (pending_results[$].mi_value != directed[k].fixed_mi
                        || pending_results[$].above != directed[k].fixed_above
                        || pending_results[$].range_err != directed[k].fixed_err) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("directed row %0d disagrees", k);
                end
            end
        end
        wait_idle();

        // count register extremes: zero acts as one (single row or column, mi 0), 31 clamps to 16
        set_counts(0, 31, 32'hFFFF_FFFF);
        send_sample(0, 5, 17'd65536, 0, 0);
        send_sample(0, 15, 17'd1, 1, 0);
        wait_idle();
        set_counts(31, 0, 32'd0);
        send_sample(15, 0, 17'd65536, 1, 0);
        wait_idle();
        // counts changed inside a set: cells left outside the region are ignored
        set_counts(16, 16, 32'd0);
        send_sample(15, 15, 17'h1FFFF, 0, 0);
        send_sample(3, 3, 17'd65536, 0, 0);
        wait_idle();
        set_counts(4, 4, 32'h0100_0000);
        send_sample(3, 3, 17'd65536, 0, 0);
        send_sample(0, 1, 17'd65536, 1, 0);
        wait_idle();

        // random sets, mostly small tables, occasional full 16x16
        sent = 0;
        while (sent < 1550) begin
            if ($urandom_range(0, 9) == 0) begin
                nf = 16; ns = 16;
            end else begin
                nf = $urandom_range(1, 5); ns = $urandom_range(1, 5);
            end
            rx_mode = $urandom_range(0, 2);
            set_counts(nf, ns, ($urandom_range(0, 3) == 0) ? $urandom()
                                                            : $urandom_range(0, 32'h1000_0000));
            set_len = $urandom_range(1, 40);
            for (int n = 0; n < set_len; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    f = 4'($urandom()); s = 4'($urandom());
                end else begin
                    f = 4'($urandom_range(0, nf - 1)); s = 4'($urandom_range(0, ns - 1));
                    // diagonal bias gives larger mi values
                    if ($urandom_range(0, 1) == 0 && ns > f) s = f;
                end
                case ($urandom_range(0, 5))
                    0:       w = 17'h1FFFF;
                    1:       w = 17'd65536;
                    2:       w = 0;
                    default: w = 17'($urandom_range(0, 17'h1FFFF));
                endcase
                send_sample(f, s, w, n == set_len - 1, 1);
                sent++;
            end
            wait_idle();
        end

        s_valid <= 0;
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
